[rtl/core/stbp_pkg.sv]
// Shared types and constants for the session token bucket policer.
package stbp_pkg;

	localparam int SESS_W   = 10;
	localparam int SESSIONS = 1 << SESS_W;

	localparam int TOK_W  = 24;
	localparam int TIME_W = 48;
	localparam int RATE_W = 16;
	localparam int SIZE_W = 16;
	localparam int MIN_W  = 11;
	localparam int APP_W  = 16;
	localparam int ENT_W  = TOK_W + TIME_W;
	localparam int PROD_W = TOK_W + RATE_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE      = 3'd0,
		CFG_RATE      = 3'd1,
		CFG_BUCKET    = 3'd2,
		CFG_WIN_EN    = 3'd3,
		CFG_WIN_BEGIN = 3'd4,
		CFG_WIN_END   = 3'd5,
		CFG_APP       = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_LIMIT = 2'd0,
		MODE_PASS  = 2'd1,
		MODE_DROP  = 2'd2
	} mode_t;

	localparam logic [MIN_W-1:0] WIN_END_RST = 11'd1440;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_MUL,
		ST_WRITE
	} state_t;

endpackage

[rtl/core/session_token_bucket_policer_top.sv]
// Per-session token bucket policer: config registers, session table, RMW sequencer.
// Each request passes the CALC, MUL and WRITE states; the result is registered on
// leaving WRITE, which waits while a held result is stalled. No new request is taken
// until the read-modify-write of the session table is done (read, interval, refill
// product, charge and write back). Reset: async, active low; clears config to
// defaults, then a clearing pass zeroes all 1024 table entries with in_stall high.
module session_token_bucket_policer_top
	import stbp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  process,
	input  logic [SESS_W-1:0]     session,
	input  logic                  app_known,
	input  logic [APP_W-1:0]      app_id,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic [MIN_W-1:0]      minute_of_day,
	input  logic [SIZE_W-1:0]     packet_size,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  pass,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration
	logic [1:0]        mode_q;
	logic [RATE_W-1:0] rate_q;
	logic [TOK_W-1:0]  bucket_q;
	logic              win_en_q;
	logic [MIN_W-1:0]  win_begin_q;
	logic [MIN_W-1:0]  win_end_q;
	logic [APP_W-1:0]  app_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_PASS;
			rate_q      <= '0;
			bucket_q    <= '0;
			win_en_q    <= 1'b0;
			win_begin_q <= '0;
			win_end_q   <= WIN_END_RST;
			app_q       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE:      mode_q      <= cfg_data[1:0];
				CFG_RATE:      rate_q      <= cfg_data[RATE_W-1:0];
				CFG_BUCKET:    bucket_q    <= cfg_data[TOK_W-1:0];
				CFG_WIN_EN:    win_en_q    <= cfg_data[0];
				CFG_WIN_BEGIN: win_begin_q <= cfg_data[MIN_W-1:0];
				CFG_WIN_END:   win_end_q   <= cfg_data[MIN_W-1:0];
				CFG_APP:       app_q       <= cfg_data[APP_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	state_t            state_q, state_d;
	logic [SESS_W-1:0] clr_q;
	logic              out_valid_q;
	logic              pass_q;
	logic              accept;
	logic              out_load;
	logic              clr_last;

	assign accept   = in_valid && !in_stall;
	assign clr_last = (clr_q == SESS_W'(SESSIONS - 1));

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = ST_CALC;
			end
			ST_CALC: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign pass      = pass_q;

	// captured request
	logic              process_s1;
	logic [SESS_W-1:0] sess_s1;
	logic              app_known_s1;
	logic [APP_W-1:0]  app_id_s1;
	logic [TIME_W-1:0] now_s1;
	logic [MIN_W-1:0]  minute_s1;
	logic [SIZE_W-1:0] size_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			process_s1   <= process;
			sess_s1      <= session;
			app_known_s1 <= app_known;
			app_id_s1    <= app_id;
			now_s1       <= now_ms;
			minute_s1    <= minute_of_day;
			size_s1      <= packet_size;
		end
	end

	// session table: {tokens, last time}
	logic [ENT_W-1:0]  mem [SESSIONS];
	logic [ENT_W-1:0]  mem_rd_s1;
	logic              mem_we;
	logic [SESS_W-1:0] mem_wa;
	logic [ENT_W-1:0]  mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (accept) mem_rd_s1 <= mem[session];
	end

	// interval stage
	logic [TIME_W-1:0] last_time;
	logic [TIME_W-1:0] interval;
	logic              in_win;
	logic [TOK_W-1:0]  gap_s2;
	logic              sat_s2;
	logic              policed_s2;
	logic [TOK_W-1:0]  tok_s2;

	assign last_time = mem_rd_s1[TIME_W-1:0];
	assign interval  = (now_s1 > last_time) ? now_s1 - last_time : '0;
	assign in_win    = !win_en_q || (minute_s1 > win_begin_q && minute_s1 < win_end_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			// an interval of 2^24 ms or more overflows any bucket when rate is nonzero
			sat_s2     <= (interval[TIME_W-1:TOK_W] != '0) && (rate_q != '0);
			gap_s2     <= interval[TOK_W-1:0];
			policed_s2 <= app_known_s1 && (app_id_s1 == app_q) && in_win;
			tok_s2     <= mem_rd_s1[ENT_W-1:TIME_W];
		end
	end

	// refill product stage
	logic [PROD_W-1:0] prod_s3;

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) prod_s3 <= PROD_W'(gap_s2) * PROD_W'(rate_q);
	end

	// charge stage
	logic [PROD_W:0]  total;
	logic [TOK_W-1:0] capped;
	logic             fits;
	logic [TOK_W-1:0] new_tok;
	logic             limited;
	logic             verdict;

	always_comb begin
		total = {{(PROD_W + 1 - TOK_W){1'b0}}, tok_s2} + {1'b0, prod_s3};
		if (sat_s2 || total > {{(PROD_W + 1 - TOK_W){1'b0}}, bucket_q}) capped = bucket_q;
		else capped = total[TOK_W-1:0];
		fits    = {{(TOK_W - SIZE_W){1'b0}}, size_s1} <= capped;
		new_tok = fits ? capped - {{(TOK_W - SIZE_W){1'b0}}, size_s1} : capped;
		limited = policed_s2 && (mode_q[1:0] == MODE_LIMIT);
		// drop bit wins over pass bit, so mode three drops
		priority if (!process_s1 || !policed_s2) verdict = 1'b1;
		else if (mode_q[1])                      verdict = 1'b0;
		else if (mode_q[0])                      verdict = 1'b1;
		else                                     verdict = fits;
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else begin
			mem_we = out_load && process_s1;
			mem_wa = sess_s1;
			mem_wd = {(limited ? new_tok : tok_s2), now_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) pass_q <= verdict;
	end

endmodule

[rtl/core/stbp_checker.sv]
// Port-level assertions for the session token bucket policer, bound to the top level.
module stbp_checker
	import stbp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic pass,
	input logic cfg_valid,
	input logic cfg_ready
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pass))
		else $error("result changed while stalled");

	// one request in flight: no new request is taken while the accepted one is processed
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall [*3])
		else $error("request accepted while another is in flight");

	// a new result only appears at the end of a busy request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a request");

	// config writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write not taken");

endmodule

bind session_token_bucket_policer_top stbp_checker u_stbp_checker (.*);
